[src/hfcd_pkg.sv]
// package: item types, crc step and scaling constants for the humidity frame decoder
`timescale 1ns / 1ps

package hfcd_pkg;

    localparam logic [7:0]  CRC_POLY    = 8'h31;
    localparam logic [7:0]  CRC_INIT    = 8'hFF;
    localparam logic [14:0] TEMP_SCALE  = 15'd17500;
    localparam logic [14:0] TEMP_OFFSET = 15'd4500;
    localparam logic [13:0] HUM_SCALE   = 14'd10000;

    typedef enum logic [2:0] {
        POS_T_HI  = 3'd0,
        POS_T_LO  = 3'd1,
        POS_T_CRC = 3'd2,
        POS_H_HI  = 3'd3,
        POS_H_LO  = 3'd4,
        POS_H_CRC = 3'd5
    } pos_t;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_TEMP_CRC = 2'd1,
        STATUS_HUM_CRC  = 2'd2
    } status_t;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       frame_start;
    } byte_item_t;

    typedef struct packed {
        logic signed [14:0] temperature_centi;
        logic        [13:0] humidity_centi;
        status_t            status;
    } result_item_t;

    // one byte through crc-8, msb first
    function automatic logic [7:0] crc8_feed(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage

[src/humidity_frame_crc_decoder.sv]
// top level: six-byte sensor frame crc check and scaling to centi-units
//
//  channel | valid        | stall        | payload
//  --------+--------------+--------------+------------------------------
//  input   | byte_valid   | byte_stall   | byte_item (byte, frame start)
//  output  | result_valid | result_stall | result (temp, humidity, status)
//
//  one byte per cycle unless a held result stalls; each byte passes the input register
//  a result appears at the edge its sixth byte leaves the input register
//  temperature multiply runs on the second byte, humidity multiply on the sixth
//  reset clears frame position, crc, t_bad and both valid flags; no clearing pass
//  a held result stalls the input only when the sixth byte of the next frame is waiting
`timescale 1ns / 1ps

module humidity_frame_crc_decoder
    import hfcd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         byte_valid,
    output logic         byte_stall,
    input  byte_item_t   byte_item,
    output logic         result_valid,
    input  logic         result_stall,
    output result_item_t result
);

    logic               s1_valid_reg, s1_valid_next;
    byte_item_t         s1_item_reg;
    pos_t               pos_reg, pos_next;
    logic [7:0]         crc_reg, crc_next;
    logic [7:0]         t_hi_reg;
    logic signed [14:0] temp_reg;
    logic [7:0]         h_hi_reg;
    logic [7:0]         h_lo_reg;
    logic               t_bad_reg, t_bad_next;
    logic               out_valid_reg, out_valid_next;
    result_item_t       out_reg;

    pos_t        pos_eff;
    logic        is_last;
    logic        proc_fire;
    logic        accept;
    logic [30:0] t_prod;
    logic [29:0] h_prod;
    logic [14:0] t_off;
    logic [7:0]  crc_step;

    always_comb
    begin
        if (s1_item_reg.frame_start || pos_reg > POS_H_CRC)
        begin
            pos_eff = POS_T_HI;
        end
        else
        begin
            pos_eff = pos_reg;
        end
    end

    assign is_last    = (pos_eff == POS_H_CRC);
    assign proc_fire  = s1_valid_reg && (!is_last || !out_valid_reg || !result_stall);
    assign byte_stall = s1_valid_reg && !proc_fire;
    assign accept     = byte_valid && !byte_stall;

    assign t_prod = 31'(TEMP_SCALE) * 31'({t_hi_reg, s1_item_reg.byte_value});
    assign t_off  = t_prod[30:16];
    assign h_prod = 30'(HUM_SCALE) * 30'({h_hi_reg, h_lo_reg});

    always_comb
    begin
        if (pos_eff == POS_T_HI || pos_eff == POS_H_HI)
        begin
            crc_step = crc8_feed(CRC_INIT, s1_item_reg.byte_value);
        end
        else
        begin
            crc_step = crc8_feed(crc_reg, s1_item_reg.byte_value);
        end
    end

    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        pos_next       = pos_reg;
        crc_next       = crc_reg;
        t_bad_next     = t_bad_reg;
        out_valid_next = out_valid_reg && result_stall;
        if (proc_fire)
        begin
            s1_valid_next = 1'b0;
            pos_next      = is_last ? POS_T_HI : pos_t'(pos_eff + 3'd1);
            unique case (pos_eff)
                POS_T_HI, POS_T_LO, POS_H_HI, POS_H_LO:
                begin
                    crc_next = crc_step;
                end
                POS_T_CRC:
                begin
                    t_bad_next = (crc_reg != s1_item_reg.byte_value);
                    crc_next   = CRC_INIT;
                end
                default:
                begin
                    crc_next       = CRC_INIT;
                    out_valid_next = 1'b1;
                end
            endcase
        end
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            pos_reg       <= POS_T_HI;
            crc_reg       <= CRC_INIT;
            t_bad_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            pos_reg       <= pos_next;
            crc_reg       <= crc_next;
            t_bad_reg     <= t_bad_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_item_reg <= byte_item;
        end
        if (proc_fire)
        begin
            unique case (pos_eff)
                POS_T_HI:
                begin
                    t_hi_reg <= s1_item_reg.byte_value;
                end
                POS_T_LO:
                begin
                    temp_reg <= $signed(15'(t_off - TEMP_OFFSET));
                end
                POS_H_HI:
                begin
                    h_hi_reg <= s1_item_reg.byte_value;
                end
                POS_H_LO:
                begin
                    h_lo_reg <= s1_item_reg.byte_value;
                end
                POS_H_CRC:
                begin
                    out_reg.temperature_centi <= temp_reg;
                    out_reg.humidity_centi    <= h_prod[29:16];
                    if (t_bad_reg)
                    begin
                        out_reg.status <= STATUS_TEMP_CRC;
                    end
                    else if (crc_reg != s1_item_reg.byte_value)
                    begin
                        out_reg.status <= STATUS_HUM_CRC;
                    end
                    else
                    begin
                        out_reg.status <= STATUS_OK;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

`ifndef SYNTHESIS
    a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(proc_fire && is_last))
        else $error("result raised without a closing byte");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        !(proc_fire && is_last && out_valid_reg && result_stall))
        else $error("held result overwritten");

    a_crc_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (proc_fire && pos_eff == POS_T_CRC) |=> (crc_reg == CRC_INIT))
        else $error("crc not restarted after temperature check byte");

    a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        byte_stall |-> (s1_valid_reg && is_last && out_valid_reg))
        else $error("input stalled without a blocked closing byte");
`endif

endmodule
